@@ hw/rtl/depq_pkg.sv @@
// Shared types and constants for the double-ended priority queue.
// Holds the item structs, the action and status codes and the sizing constants.
// No dependencies.
package depq_pkg;

  localparam int Capacity = 16;
  localparam int CountW   = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    ACT_INSERT  = 3'd0,
    ACT_REM_MIN = 3'd1,
    ACT_REM_MAX = 3'd2,
    ACT_REM_VAL = 3'd3,
    ACT_QUERY   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic        [2:0]  action;
    logic signed [31:0] value;
  } depq_in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] removed_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic        [4:0]  count;
    logic               is_empty;
  } depq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted item
    logic exec;  // apply the captured item to the store
  } depq_cmd_t;

endpackage

@@ hw/rtl/depq_ctrl.sv @@
// Controller for the double-ended priority queue.
// Sequences capture, execution and result hand-off; depends on depq_pkg.
module depq_ctrl import depq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output depq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   in_stall_q;
  logic   out_valid_q;
  logic   accept;

  assign accept      = in_valid_i && !in_stall_q;
  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.exec  = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q    <= S_EXEC;
            in_stall_q <= 1'b1;
          end
        end
        S_EXEC: begin
          state_q     <= S_RESP;
          out_valid_q <= 1'b1;
        end
        S_RESP: begin
          if (!out_stall_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_stall_q  <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
          in_stall_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/depq_datapath.sv @@
// Datapath for the double-ended priority queue: a row of sorted cells that
// shift up or down in one step, plus the result registers. Depends on depq_pkg.
module depq_datapath import depq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  depq_cmd_t cmd_i,
  input  depq_in_t  item_i,
  output depq_out_t result_o
);

  depq_in_t           item_q;
  logic signed [31:0] cells_q [Capacity];
  logic signed [31:0] cells_d [Capacity];
  logic [CountW-1:0]  count_q, count_d;
  logic [1:0]         status_q, status_d;
  logic signed [31:0] removed_q, removed_d;

  logic [Capacity-1:0] valid, le, eq, seen, last;
  logic signed [31:0]  up   [Capacity];
  logic signed [31:0]  down [Capacity];
  logic signed [31:0]  max_sel;
  logic                full, empty, found;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      valid[i] = CountW'(i) < count_q;
      last[i]  = CountW'(i + 1) == count_q;
      le[i]    = valid[i] && (cells_q[i] <= item_q.value);
      eq[i]    = valid[i] && (cells_q[i] == item_q.value);
    end
    // First matching cell and everything above it shift down on a value remove.
    seen[0] = eq[0];
    for (int i = 1; i < Capacity; i++) begin
      seen[i] = seen[i-1] | eq[i];
    end
    for (int i = 0; i < Capacity - 1; i++) begin
      up[i] = cells_q[i+1];
    end
    up[Capacity-1] = cells_q[Capacity-1];
    down[0] = cells_q[0];
    for (int i = 1; i < Capacity; i++) begin
      down[i] = cells_q[i-1];
    end
    max_sel = '0;
    for (int i = 0; i < Capacity; i++) begin
      max_sel = max_sel | (last[i] ? cells_q[i] : 32'sd0);
    end
  end

  assign full  = (count_q == CountW'(Capacity));
  assign empty = (count_q == '0);
  assign found = seen[Capacity-1];

  always_comb begin
    cells_d   = cells_q;
    count_d   = count_q;
    status_d  = ST_OK;
    removed_d = '0;
    case (item_q.action)
      ACT_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          // Equal values stay below the new one, so arrival order is kept.
          if (!le[0]) cells_d[0] = item_q.value;
          for (int i = 1; i < Capacity; i++) begin
            if (!le[i]) begin
              cells_d[i] = le[i-1] ? item_q.value : down[i];
            end
          end
          count_d = count_q + 1'b1;
        end
      end
      ACT_REM_MIN: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = cells_q[0];
          cells_d   = up;
          count_d   = count_q - 1'b1;
        end
      end
      ACT_REM_MAX: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = max_sel;
          count_d   = count_q - 1'b1;
        end
      end
      ACT_REM_VAL: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOTFOUND;
        end else begin
          removed_d = item_q.value;
          for (int i = 0; i < Capacity; i++) begin
            if (seen[i]) cells_d[i] = up[i];
          end
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      cells_q   <= cells_d;
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  assign result_o.status        = status_q;
  assign result_o.removed_value = removed_q;
  assign result_o.min_value     = empty ? 32'sd0 : cells_q[0];
  assign result_o.max_value     = max_sel;
  assign result_o.count         = 5'(count_q);
  assign result_o.is_empty      = empty;

endmodule

@@ hw/rtl/double_ended_priority_queue.sv @@
// Double-ended priority queue over a sorted row of cells.
// The accepted item is captured, then all cells are compared and shifted in
// one step, and the result is registered and held until it is taken.
// The controller keeps one item in flight and takes no new item until the
// result is taken (capture, compare-and-shift of all cells, result hand-off).
// Reset: asynchronous, active low; empties the store, cell contents undefined.
module double_ended_priority_queue import depq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  depq_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output depq_out_t out_item_o
);

  depq_cmd_t cmd;

  depq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  depq_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (in_item_i),
    .result_o (out_item_o)
  );

endmodule

@@ hw/rtl/depq_checker.sv @@
// Port-level checks for the double-ended priority queue.
// Bound to the top level below; depends on depq_pkg.
module depq_checker import depq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input depq_in_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input depq_out_t out_item_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Only one item is in flight, so input is held off while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.is_empty == (out_item_o.count == 5'd0))
                    && (out_item_o.count <= 5'(Capacity)))
    else $error("count and empty flag disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.is_empty |-> out_item_o.min_value <= out_item_o.max_value)
    else $error("minimum above maximum");

  // An accepted item leaves the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted back to back");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

@@ dv/tb_double_ended_priority_queue.sv @@
// Self-checking testbench for the double-ended priority queue.
// A sorted-store predictor models the queue; results are checked field by field.
// Depends on depq_pkg and the double_ended_priority_queue top level.
`timescale 1ns / 1ps

module tb_double_ended_priority_queue;
  import depq_pkg::*;

  localparam logic signed [31:0] IntMin = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax = 32'sh7fff_ffff;

  // Receiver stall patterns.
  localparam int StallNone   = 0;
  localparam int StallLight  = 1;
  localparam int StallPeriod = 2;
  localparam int StallHeavy  = 3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  depq_in_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  depq_out_t out_item;

  double_ended_priority_queue u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #10 clk = ~clk;

  // Predictor state: the values held, ascending, and how many there are.
  logic signed [31:0] held_vals [Capacity];
  int                 held_cnt = 0;

  depq_out_t pending_q [$];
  int        mismatches  = 0;
  int        items_sent  = 0;
  int        checked     = 0;
  int        full_drops  = 0;
  int        empty_hits  = 0;
  int        miss_hits   = 0;
  int        stall_mode  = StallNone;
  int        stall_phase = 0;
  bit        pace_on     = 1'b0;
  int        burst_left  = 0;

  // Applies one item to the predicted store and returns the result it should give.
  function automatic depq_out_t apply_op(depq_in_t it);
    depq_out_t res;
    int        pos;
    res = '0;
    res.status = ST_OK;
    case (it.action)
      ACT_INSERT: begin
        if (held_cnt == Capacity) begin
          res.status = ST_FULL;
        end else begin
          // Equal values go after the ones already held.
          pos = 0;
          while (pos < held_cnt && held_vals[pos] <= it.value) pos++;
          for (int i = held_cnt; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = it.value;
          held_cnt++;
        end
      end
      ACT_REM_MIN: begin
        if (held_cnt == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_value = held_vals[0];
          for (int i = 0; i + 1 < held_cnt; i++) held_vals[i] = held_vals[i+1];
          held_cnt--;
        end
      end
      ACT_REM_MAX: begin
        if (held_cnt == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_value = held_vals[held_cnt-1];
          held_cnt--;
        end
      end
      ACT_REM_VAL: begin
        if (held_cnt == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < held_cnt && held_vals[pos] != it.value) pos++;
          if (pos == held_cnt) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.removed_value = it.value;
            for (int i = pos; i + 1 < held_cnt; i++) held_vals[i] = held_vals[i+1];
            held_cnt--;
          end
        end
      end
      default: ;
    endcase
    res.min_value = (held_cnt == 0) ? '0 : held_vals[0];
    res.max_value = (held_cnt == 0) ? '0 : held_vals[held_cnt-1];
    res.count     = 5'(held_cnt);
    res.is_empty  = (held_cnt == 0);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    depq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t ns: unexpected result, actual %0h", $time, out_item);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_EMPTY) empty_hits++;
        if (want.status == ST_NOTFOUND) miss_hits++;
        check_field("status", 32'(want.status), 32'(out_item.status));
        check_field("removed_value", want.removed_value, out_item.removed_value);
        check_field("min_value", want.min_value, out_item.min_value);
        check_field("max_value", want.max_value, out_item.max_value);
        check_field("count", 32'(want.count), 32'(out_item.count));
        check_field("is_empty", 32'(want.is_empty), 32'(out_item.is_empty));
      end
    end
  end

  always @(negedge clk) begin
    stall_phase++;
    case (stall_mode)
      StallLight:  out_stall <= ($urandom_range(0, 3) == 0);
      StallPeriod: out_stall <= ((stall_phase % 7) >= 4);
      StallHeavy:  out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= 1'b0;
    endcase
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(depq_in_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(apply_op(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_for(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // Sends one item, inserting a random gap between bursts when pacing is on.
  task automatic push_item(logic [2:0] act, logic signed [31:0] val);
    depq_in_t it;
    it.action = act;
    it.value  = val;
    if (pace_on && burst_left == 0) begin
      idle_for($urandom_range(1, 6));
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    send_item(it);
  endtask

  // Small values give many duplicates and hits; some are the extremes and the rest spread over all bits.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 16)) - 8;
      4: begin
        case ($urandom_range(0, 3))
          0:       return IntMin;
          1:       return IntMax;
          2:       return IntMin + 1;
          default: return IntMax - 1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [31:0] pick_target();
    if (held_cnt > 0 && $urandom_range(0, 9) < 7)
      return held_vals[$urandom_range(0, held_cnt - 1)];
    return pick_value();
  endfunction

  task automatic test_edge_cases();
    push_item(ACT_QUERY, 32'sd0);
    push_item(ACT_REM_MIN, 32'sd0);
    push_item(ACT_REM_MAX, 32'sd0);
    push_item(ACT_REM_VAL, 32'sd0);
    push_item(ACT_INSERT, IntMax);
    push_item(ACT_INSERT, IntMin);
    push_item(ACT_INSERT, 32'sd0);
    push_item(ACT_INSERT, -32'sd1);
    push_item(ACT_INSERT, 32'sd0);
    push_item(ACT_INSERT, IntMax);
    push_item(ACT_REM_VAL, 32'sd5);
    push_item(ACT_REM_VAL, 32'sd0);
    push_item(ACT_REM_VAL, IntMin);
    // Action codes past the last defined one behave as a query.
    for (int a = int'(ACT_QUERY) + 1; a < 8; a++) push_item(3'(a), IntMax);
    push_item(ACT_REM_MIN, 32'sd0);
    push_item(ACT_REM_MAX, 32'sd0);
    push_item(ACT_REM_MAX, 32'sd0);
    push_item(ACT_REM_MAX, 32'sd0);
    push_item(ACT_REM_MAX, 32'sd0);
  endtask

  task automatic test_full_and_drain(int rounds);
    for (int r = 0; r < rounds; r++) begin
      while (held_cnt < Capacity) push_item(ACT_INSERT, pick_value());
      repeat ($urandom_range(1, 3)) push_item(ACT_INSERT, pick_value());
      while (held_cnt > 0) begin
        case ($urandom_range(0, 2))
          0:       push_item(ACT_REM_MIN, pick_value());
          1:       push_item(ACT_REM_MAX, pick_value());
          default: push_item(ACT_REM_VAL, pick_target());
        endcase
      end
      push_item(3'($urandom_range(int'(ACT_REM_MIN), int'(ACT_REM_VAL))), pick_value());
    end
  endtask

  task automatic test_random_mix(int n_items);
    int ins_pct;
    int pick;
    for (int n = 0; n < n_items; n++) begin
      // Lean toward inserts when nearly empty and removes when nearly full.
      ins_pct = (held_cnt < 4) ? 60 : (held_cnt > 12) ? 25 : 40;
      if ($urandom_range(0, 99) < ins_pct) begin
        push_item(ACT_INSERT, pick_value());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25)      push_item(ACT_REM_MIN, pick_value());
        else if (pick < 50) push_item(ACT_REM_MAX, pick_value());
        else if (pick < 85) push_item(ACT_REM_VAL, pick_target());
        else                push_item(3'($urandom_range(int'(ACT_QUERY), 7)), pick_value());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_edge_cases();
    wait_drained();

    stall_mode = StallLight;
    pace_on    = 1'b1;
    test_full_and_drain(6);
    wait_drained();

    stall_mode = StallNone;
    pace_on    = 1'b0;
    test_random_mix(400);

    stall_mode = StallPeriod;
    pace_on    = 1'b1;
    test_random_mix(400);
    wait_drained();

    stall_mode = StallHeavy;
    test_random_mix(400);

    stall_mode = StallLight;
    pace_on    = 1'b0;
    test_random_mix(400);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d items and checked %0d results.", items_sent, checked);
    $display("Dropped full inserts: %0d, removes on empty: %0d, values not found: %0d.",
             full_drops, empty_hits, miss_hits);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still outstanding.", pending_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ double_ended_priority_queue.f @@
hw/rtl/depq_pkg.sv
hw/rtl/depq_ctrl.sv
hw/rtl/depq_datapath.sv
hw/rtl/double_ended_priority_queue.sv
hw/rtl/depq_checker.sv
dv/tb_double_ended_priority_queue.sv
